### src/blstp_pkg.sv
// blstp_pkg: shared constants and types for the Bresenham line stepper.
// No dependencies; imported by every module of the block.
package blstp_pkg;

    localparam int FW_BITS    = 13;
    localparam int ADDR_BITS  = 24;
    localparam int COLOR_BITS = 32;

    localparam logic [FW_BITS-1:0] FW_RESET = 13'd640;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_STEP = 1'b1
    } t_mode;

endpackage

### src/blstp_front.sv
// blstp_front: accepts input words and classifies them into queue commands.
// A load word gets its deltas, step directions and major axis worked out here.
// Depends on blstp_pkg.
module blstp_front #(
    parameter int COORD_BITS = 12,
    parameter int CMD_W      = 4 + 5 * 12 + 32
) (
    input  logic                             i_mode,
    input  logic [COORD_BITS-1:0]            i_start_x,
    input  logic [COORD_BITS-1:0]            i_start_y,
    input  logic [COORD_BITS-1:0]            i_end_x,
    input  logic [COORD_BITS-1:0]            i_end_y,
    input  logic [blstp_pkg::COLOR_BITS-1:0] i_line_color,
    output logic [CMD_W-1:0]                 o_cmd
);
    import blstp_pkg::*;

    typedef struct packed {
        logic                  load;
        logic [COORD_BITS-1:0] x0;
        logic [COORD_BITS-1:0] y0;
        logic [COORD_BITS-1:0] end_major;
        logic [COORD_BITS-1:0] d_major;
        logic [COORD_BITS-1:0] d_minor;
        logic                  x_neg;
        logic                  y_neg;
        logic                  x_major;
        logic [COLOR_BITS-1:0] color;
    } t_cmd;

    t_cmd                  w_cmd;
    logic [COORD_BITS-1:0] w_adx;
    logic [COORD_BITS-1:0] w_ady;
    logic                  w_x_up;
    logic                  w_y_up;
    logic                  w_x_major;

    always_comb begin
        w_x_up    = (i_end_x > i_start_x);
        w_y_up    = (i_end_y > i_start_y);
        w_adx     = w_x_up ? (i_end_x - i_start_x) : (i_start_x - i_end_x);
        w_ady     = w_y_up ? (i_end_y - i_start_y) : (i_start_y - i_end_y);
        w_x_major = (w_adx > w_ady);

        w_cmd.load      = (i_mode == MODE_LOAD);
        w_cmd.x0        = i_start_x;
        w_cmd.y0        = i_start_y;
        w_cmd.end_major = w_x_major ? i_end_x : i_end_y;
        w_cmd.d_major   = w_x_major ? w_adx : w_ady;
        w_cmd.d_minor   = w_x_major ? w_ady : w_adx;
        w_cmd.x_neg     = ~w_x_up;
        w_cmd.y_neg     = ~w_y_up;
        w_cmd.x_major   = w_x_major;
        w_cmd.color     = i_line_color;
    end

    assign o_cmd = w_cmd;

endmodule

### src/blstp_fifo.sv
// blstp_fifo: small register queue between the front and the stepper.
// Count-based full and empty flags. Depends on blstp_pkg.
module blstp_fifo #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_full,
    output logic             o_empty
);
    import blstp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;
    logic [AW-1:0]    n_wr_ptr;
    logic [AW-1:0]    n_rd_ptr;
    logic [AW:0]      n_count;
    logic             w_do_wr;
    logic             w_do_rd;

    assign o_full    = (r_count == (AW+1)'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_wr   = i_wr && !o_full;
    assign w_do_rd   = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_wr) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_rd) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_wr && !w_do_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_do_rd && !w_do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

### src/blstp_back.sv
// blstp_back: line state, one error-term step per command, then the address
// stage and the output register. Depends on blstp_pkg.
module blstp_back #(
    parameter int COORD_BITS = 12,
    parameter int CMD_W      = 4 + 5 * 12 + 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [CMD_W-1:0]                 i_cmd,
    input  logic                             i_q_empty,
    output logic                             o_q_pop,
    input  logic [blstp_pkg::FW_BITS-1:0]    i_frame_width,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_pixel_valid,
    output logic [COORD_BITS-1:0]            o_pixel_x,
    output logic [COORD_BITS-1:0]            o_pixel_y,
    output logic [blstp_pkg::ADDR_BITS-1:0]  o_pixel_address,
    output logic [blstp_pkg::COLOR_BITS-1:0] o_pixel_color,
    output logic                             o_last_pixel
);
    import blstp_pkg::*;

    localparam int SW = COORD_BITS + 2;
    localparam int EW = COORD_BITS + 3;
    localparam int PW = COORD_BITS + FW_BITS;

    typedef struct packed {
        logic                  load;
        logic [COORD_BITS-1:0] x0;
        logic [COORD_BITS-1:0] y0;
        logic [COORD_BITS-1:0] end_major;
        logic [COORD_BITS-1:0] d_major;
        logic [COORD_BITS-1:0] d_minor;
        logic                  x_neg;
        logic                  y_neg;
        logic                  x_major;
        logic [COLOR_BITS-1:0] color;
    } t_cmd;

    t_cmd w_cmd;

    // line state
    logic [COORD_BITS-1:0] r_cur_x, r_cur_y, r_end_major, r_d_major, r_d_minor;
    logic signed [SW-1:0]  r_err;
    logic                  r_x_neg, r_y_neg, r_x_major, r_active;
    logic [COLOR_BITS-1:0] r_color;
    logic [COORD_BITS-1:0] n_cur_x, n_cur_y;
    logic signed [SW-1:0]  n_err;
    logic                  n_active;

    // effective state for the command at the queue head
    logic [COORD_BITS-1:0] e_x, e_y, e_end, e_dmaj, e_dmin;
    logic signed [SW-1:0]  e_err;
    logic                  e_xn, e_yn, e_xmaj, e_act;
    logic [COLOR_BITS-1:0] e_color;

    logic                  w_last;
    logic signed [EW-1:0]  w_err_sum;
    logic signed [EW-1:0]  w_err_dbl;
    logic                  w_minor_step;
    logic [COORD_BITS-1:0] w_x_inc, w_y_inc;

    // stepper stage
    logic                  r_s1_valid, r_s1_pix, r_s1_last;
    logic [COORD_BITS-1:0] r_s1_x, r_s1_y;
    logic [COLOR_BITS-1:0] r_s1_color;

    // output stage
    logic                  r_o_valid, r_o_pix, r_o_last;
    logic [COORD_BITS-1:0] r_o_x, r_o_y;
    logic [ADDR_BITS-1:0]  r_o_addr;
    logic [COLOR_BITS-1:0] r_o_color;

    logic                  w_s2_adv, w_s1_adv, w_pop;
    logic [PW-1:0]         w_prod;
    logic [PW:0]           w_addr_sum;

    assign w_cmd    = i_cmd;
    assign w_s2_adv = !r_o_valid || !i_out_stall;
    assign w_s1_adv = !r_s1_valid || w_s2_adv;
    assign w_pop    = !i_q_empty && w_s1_adv;
    assign o_q_pop  = w_pop;

    always_comb begin
        if (w_cmd.load) begin
            e_x     = w_cmd.x0;
            e_y     = w_cmd.y0;
            e_end   = w_cmd.end_major;
            e_dmaj  = w_cmd.d_major;
            e_dmin  = w_cmd.d_minor;
            e_xn    = w_cmd.x_neg;
            e_yn    = w_cmd.y_neg;
            e_xmaj  = w_cmd.x_major;
            e_err   = '0;
            e_act   = 1'b1;
            e_color = w_cmd.color;
        end else begin
            e_x     = r_cur_x;
            e_y     = r_cur_y;
            e_end   = r_end_major;
            e_dmaj  = r_d_major;
            e_dmin  = r_d_minor;
            e_xn    = r_x_neg;
            e_yn    = r_y_neg;
            e_xmaj  = r_x_major;
            e_err   = r_err;
            e_act   = r_active;
            e_color = r_color;
        end
    end

    always_comb begin
        w_last       = ((e_xmaj ? e_x : e_y) == e_end);
        w_err_sum    = EW'(e_err) + $signed(EW'(e_dmin));
        w_err_dbl    = w_err_sum <<< 1;
        w_minor_step = (w_err_dbl >= $signed(EW'(e_dmaj)));
        w_x_inc      = e_xn ? (e_x - 1'b1) : (e_x + 1'b1);
        w_y_inc      = e_yn ? (e_y - 1'b1) : (e_y + 1'b1);

        n_cur_x  = e_x;
        n_cur_y  = e_y;
        n_err    = e_err;
        n_active = e_act;
        if (e_act) begin
            if (w_last) begin
                n_active = 1'b0;
            end else begin
                n_err = w_minor_step ? SW'(w_err_sum - $signed(EW'(e_dmaj)))
                                     : SW'(w_err_sum);
                if (e_xmaj) begin
                    n_cur_x = w_x_inc;
                    if (w_minor_step) begin
                        n_cur_y = w_y_inc;
                    end
                end else begin
                    n_cur_y = w_y_inc;
                    if (w_minor_step) begin
                        n_cur_x = w_x_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (w_pop) begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_err       <= n_err;
            r_end_major <= e_end;
            r_d_major   <= e_dmaj;
            r_d_minor   <= e_dmin;
            r_x_neg     <= e_xn;
            r_y_neg     <= e_yn;
            r_x_major   <= e_xmaj;
            r_color     <= e_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_s1_valid <= w_pop;
        end
    end

    // idle step words carry all-zero payload
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_s1_pix   <= e_act;
            r_s1_x     <= e_act ? e_x : '0;
            r_s1_y     <= e_act ? e_y : '0;
            r_s1_color <= e_act ? e_color : '0;
            r_s1_last  <= e_act && w_last;
        end
    end

    assign w_prod     = PW'(r_s1_y) * PW'(i_frame_width);
    assign w_addr_sum = (PW+1)'(w_prod) + (PW+1)'(r_s1_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_s2_adv) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_adv && r_s1_valid) begin
            r_o_pix   <= r_s1_pix;
            r_o_x     <= r_s1_x;
            r_o_y     <= r_s1_y;
            r_o_addr  <= ADDR_BITS'(w_addr_sum);
            r_o_color <= r_s1_color;
            r_o_last  <= r_s1_last;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_pixel_valid   = r_o_pix;
    assign o_pixel_x       = r_o_x;
    assign o_pixel_y       = r_o_y;
    assign o_pixel_address = r_o_addr;
    assign o_pixel_color   = r_o_color;
    assign o_last_pixel    = r_o_last;

endmodule

### src/bresenham_line_stepper.sv
// bresenham_line_stepper: top level of the Bresenham line stepper.
// Instantiates blstp_front, blstp_fifo and blstp_back; depends on blstp_pkg.
//
// One result word per input word, one pixel per clock sustained while words
// are queued and the output is not stalled. A load word (mode 0) starts a
// line and returns its first pixel; each step word (mode 1) returns the next
// pixel, or a word with pixel_valid low when no line is active. A word passes
// the command queue, the stepper stage register (error-term step done on pop)
// and the y*frame_width+x address multiply-add into the output register. The
// four-entry queue lets input and output stall independently. The user must
// write frame_width only while the block is idle; not enforced by the block.
module bresenham_line_stepper #(
    parameter int COORD_BITS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [blstp_pkg::FW_BITS-1:0]    i_cfg_wr_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_mode,
    input  logic [COORD_BITS-1:0]            i_start_x,
    input  logic [COORD_BITS-1:0]            i_start_y,
    input  logic [COORD_BITS-1:0]            i_end_x,
    input  logic [COORD_BITS-1:0]            i_end_y,
    input  logic [blstp_pkg::COLOR_BITS-1:0] i_line_color,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_pixel_valid,
    output logic [COORD_BITS-1:0]            o_pixel_x,
    output logic [COORD_BITS-1:0]            o_pixel_y,
    output logic [blstp_pkg::ADDR_BITS-1:0]  o_pixel_address,
    output logic [blstp_pkg::COLOR_BITS-1:0] o_pixel_color,
    output logic                             o_last_pixel
);
    import blstp_pkg::*;

    localparam int CMD_W       = 4 + 5 * COORD_BITS + COLOR_BITS;
    localparam int QUEUE_DEPTH = 4;

    logic [FW_BITS-1:0] r_frame_width;
    logic [CMD_W-1:0]   w_front_cmd;
    logic [CMD_W-1:0]   w_head_cmd;
    logic               w_q_full;
    logic               w_q_empty;
    logic               w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width <= FW_RESET;
        end else if (i_cfg_wr_en) begin
            r_frame_width <= i_cfg_wr_data;
        end
    end

    assign o_in_stall = w_q_full;

    blstp_front #(
        .COORD_BITS (COORD_BITS),
        .CMD_W      (CMD_W)
    ) u_front (
        .i_mode       (i_mode),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_line_color (i_line_color),
        .o_cmd        (w_front_cmd)
    );

    blstp_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (i_in_valid),
        .i_wr_data (w_front_cmd),
        .i_rd      (w_q_pop),
        .o_rd_data (w_head_cmd),
        .o_full    (w_q_full),
        .o_empty   (w_q_empty)
    );

    blstp_back #(
        .COORD_BITS (COORD_BITS),
        .CMD_W      (CMD_W)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_head_cmd),
        .i_q_empty       (w_q_empty),
        .o_q_pop         (w_q_pop),
        .i_frame_width   (r_frame_width),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_pixel_valid   (o_pixel_valid),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_pixel_address (o_pixel_address),
        .o_pixel_color   (o_pixel_color),
        .o_last_pixel    (o_last_pixel)
    );

    a_idle_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_pixel_valid) |->
            (o_pixel_x == '0 && o_pixel_y == '0 && o_pixel_address == '0 &&
             o_pixel_color == '0 && !o_last_pixel))
        else $error("idle result word carries nonzero payload");

    a_last_is_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_pixel) |-> o_pixel_valid)
        else $error("last_pixel set on a word without a pixel");

    a_accept_fills_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !w_q_empty)
        else $error("accepted word did not reach the queue");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_empty)
        else $error("stepper popped an empty queue");

endmodule
